>>> design/huffman_tree_walk_decoder_assert.svh
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder assertion macros
// Clocked implication checks, switched off as a group by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define HTWD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define HTWD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HTWD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define HTWD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/htwd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Widths, request codes, node layout and the walker state type.
// ----------------------------------------------------------------------------
package htwd_pkg;

   localparam int IDX_W              = 9;
   localparam int SYM_W              = 8;
   localparam int NODE_COUNT_DEFAULT = 512;

   // Request kinds.
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             leaf;
      logic [SYM_W-1:0] symbol;
   } node_type;

   // Access from the walker to the node memory.
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      node_type         wr_node;
   } mem_req_type;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_CUR,
      WALK_NEXT
   } walk_state_type;

endpackage

>>> design/htwd_node_mem.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder node memory
// One write and one registered read per cycle; out-of-range nodes read zero.
// ----------------------------------------------------------------------------
module htwd_node_mem #(
   parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  htwd_pkg::mem_req_type mem_req,
   output htwd_pkg::node_type   rd_node
);

   localparam int ADDR_W = $clog2(NODE_COUNT);
   localparam int WIDE_W = ADDR_W + htwd_pkg::IDX_W;

   htwd_pkg::node_type node_mem [NODE_COUNT];
   htwd_pkg::node_type rd_data_ff;
   logic               rd_ok_ff;

   logic [WIDE_W-1:0] rd_wide;
   logic [WIDE_W-1:0] wr_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_in_range;
   logic              wr_in_range;

   assign rd_wide     = {{ADDR_W{1'b0}}, mem_req.rd_idx};
   assign wr_wide     = {{ADDR_W{1'b0}}, mem_req.wr_idx};
   assign rd_addr     = rd_wide[ADDR_W-1:0];
   assign wr_addr     = wr_wide[ADDR_W-1:0];
   assign rd_in_range = rd_wide < WIDE_W'(NODE_COUNT);
   assign wr_in_range = wr_wide < WIDE_W'(NODE_COUNT);

   always_ff @(posedge clock) begin
      if (mem_req.wr_en && wr_in_range) begin
         node_mem[wr_addr] <= mem_req.wr_node;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_ok_ff <= rd_in_range;
         if (rd_in_range) begin
            rd_data_ff <= node_mem[rd_addr];
         end
      end
   end

   // A node beyond the table is a non-leaf with both children and symbol zero.
   assign rd_node = rd_ok_ff ? rd_data_ff : '0;

endmodule

>>> design/htwd_walker.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder walker
// Holds root and cursor, sequences node reads and writes and registers the result.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_assert.svh"

module htwd_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          req_kind,
   input  logic [htwd_pkg::IDX_W-1:0]    req_node_index,
   input  logic [htwd_pkg::IDX_W-1:0]    req_left_index,
   input  logic [htwd_pkg::IDX_W-1:0]    req_right_index,
   input  logic                          req_leaf,
   input  logic [htwd_pkg::SYM_W-1:0]    req_leaf_symbol,
   input  logic                          req_code_bit,
   input  logic                          csr_valid,
   input  logic [htwd_pkg::IDX_W-1:0]    csr_root_index,
   input  htwd_pkg::node_type            rd_node,
   output htwd_pkg::mem_req_type         mem_req,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic [htwd_pkg::SYM_W-1:0]    rsp_symbol
);

   htwd_pkg::walk_state_type         state_ff, state_in;
   logic [htwd_pkg::IDX_W-1:0]       cursor_ff, cursor_in;
   logic [htwd_pkg::IDX_W-1:0]       root_ff, root_in;
   logic                             bit_ff, bit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [htwd_pkg::SYM_W-1:0]       rsp_symbol_ff, rsp_symbol_in;
   logic [htwd_pkg::IDX_W-1:0]       child;
   logic                             accept;

   assign busy   = (state_ff != htwd_pkg::WALK_IDLE);
   assign accept = start && !busy;
   assign child  = bit_ff ? rd_node.right : rd_node.left;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htwd_pkg::WALK_IDLE;
         cursor_ff    <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff        <= bit_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      mem_req       = '0;
      unique case (state_ff)
         htwd_pkg::WALK_IDLE: begin
            if (csr_valid) begin
               root_in   = csr_root_index;
               cursor_in = csr_root_index;
            end
            if (accept) begin
               if (req_kind == htwd_pkg::KIND_WRITE) begin
                  mem_req.wr_en          = 1'b1;
                  mem_req.wr_idx         = req_node_index;
                  mem_req.wr_node.left   = req_left_index;
                  mem_req.wr_node.right  = req_right_index;
                  mem_req.wr_node.leaf   = req_leaf;
                  mem_req.wr_node.symbol = req_leaf_symbol;
                  cursor_in              = root_ff;
               end else begin
                  mem_req.rd_en  = 1'b1;
                  mem_req.rd_idx = cursor_ff;
                  bit_in         = req_code_bit;
                  state_in       = htwd_pkg::WALK_CUR;
               end
            end
         end
         htwd_pkg::WALK_CUR: begin
            if (rd_node.leaf) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = rd_node.symbol;
               cursor_in     = root_ff;
               state_in      = htwd_pkg::WALK_IDLE;
            end else begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_idx = child;
               cursor_in      = child;
               state_in       = htwd_pkg::WALK_NEXT;
            end
         end
         htwd_pkg::WALK_NEXT: begin
            if (rd_node.leaf) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = rd_node.symbol;
               cursor_in     = root_ff;
            end
            state_in = htwd_pkg::WALK_IDLE;
         end
         default: begin
            state_in = htwd_pkg::WALK_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;

   `HTWD_ASSERT_IMP(a_rsp_after_eval, clock, reset, rsp_valid_ff, $past(state_ff) == htwd_pkg::WALK_CUR || $past(state_ff) == htwd_pkg::WALK_NEXT, "result without a node evaluation")
   `HTWD_ASSERT_IMP(a_rsp_cursor_root, clock, reset, rsp_valid_ff, cursor_ff == root_ff, "cursor not at root after a result")
   `HTWD_ASSERT_IMP(a_write_when_idle, clock, reset, mem_req.wr_en, state_ff == htwd_pkg::WALK_IDLE && !mem_req.rd_en, "node write during a walk")
   `HTWD_ASSERT_NXT(a_next_from_cur, clock, reset, state_ff == htwd_pkg::WALK_CUR && !rd_node.leaf, state_ff == htwd_pkg::WALK_NEXT && $past(mem_req.rd_en), "child read not issued")

endmodule

>>> design/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder
// Walks a code tree held in a node memory, one coded bit per request.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. A node
// write request stores one tree node and sends the cursor back to the root; it
// never raises busy. A decode request launches a read of the node under the
// cursor in the accept cycle, and if that node is not a leaf a further read
// fetches the child chosen by the code bit. Each step waits on the registered
// read of the node memory. When a leaf is reached its symbol appears on
// rsp_symbol with rsp_valid high for exactly one cycle, the cycle after the
// node memory returns that leaf; the receiver cannot stall it, so it must take
// every symbol as it comes. A new request may be accepted in that same cycle.
// The root register is written through the csr_ channel, which is ready
// whenever the decoder is not busy; writing it also moves the cursor to the
// new root unless a request is accepted in the same cycle. Node memory
// contents are undefined after reset, so the tree must be loaded before it is
// walked; nodes at or beyond NODE_COUNT read as an empty non-leaf node.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
   parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_kind,
   input  logic [htwd_pkg::IDX_W-1:0] req_node_index,
   input  logic [htwd_pkg::IDX_W-1:0] req_left_index,
   input  logic [htwd_pkg::IDX_W-1:0] req_right_index,
   input  logic                       req_leaf,
   input  logic [htwd_pkg::SYM_W-1:0] req_leaf_symbol,
   input  logic                       req_code_bit,
   output logic                       rsp_valid,
   output logic [htwd_pkg::SYM_W-1:0] rsp_symbol,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [htwd_pkg::IDX_W-1:0] csr_root_index
);

   htwd_pkg::mem_req_type mem_req;
   htwd_pkg::node_type    rd_node;

   // The root register only changes between walks.
   assign csr_ready = !busy;

   // The walker owns the cursor and root and issues every memory access.
   htwd_walker u_walker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_kind        (req_kind),
      .req_node_index  (req_node_index),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .req_leaf        (req_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_code_bit    (req_code_bit),
      .csr_valid       (csr_valid),
      .csr_root_index  (csr_root_index),
      .rd_node         (rd_node),
      .mem_req         (mem_req),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol)
   );

   // The node memory holds the whole tree, one entry per node.
   htwd_node_mem #(
      .NODE_COUNT (NODE_COUNT)
   ) u_node_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_node (rd_node)
   );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder testbench
// Loads code trees into the node memory, walks them one coded bit per request
// and checks every decoded symbol against a walk model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IDX_W         = htwd_pkg::IDX_W;
   localparam int SYM_W         = htwd_pkg::SYM_W;
   localparam int NODES         = htwd_pkg::NODE_COUNT_DEFAULT;
   // A decode request keeps the block busy at most while it reads a node and its child.
   localparam int SETTLE_CYCLES = 4;
   localparam int REQUEST_GOAL  = 1900;
   localparam int SHOWN_LIMIT   = 10;

   // What the driver does with one entry of the stimulus queue.
   typedef enum logic [1:0] {
      STEP_REQUEST,
      STEP_ROOT_WRITE,
      STEP_SETTLE
   } step_kind_type;

   typedef struct packed {
      step_kind_type    op;
      logic             kind;
      logic [IDX_W-1:0] node;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             leaf;
      logic [SYM_W-1:0] symbol;
      logic             code_bit;
      logic [IDX_W-1:0] root;
   } stim_step_type;

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             start           = 1'b0;
   logic             busy;
   logic             req_kind        = htwd_pkg::KIND_WRITE;
   logic [IDX_W-1:0] req_node_index  = '0;
   logic [IDX_W-1:0] req_left_index  = '0;
   logic [IDX_W-1:0] req_right_index = '0;
   logic             req_leaf        = 1'b0;
   logic [SYM_W-1:0] req_leaf_symbol = '0;
   logic             req_code_bit    = 1'b0;
   logic             rsp_valid;
   logic [SYM_W-1:0] rsp_symbol;
   logic             csr_valid       = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_root_index  = '0;

   // Stimulus waiting for the driver, and decoded symbols waiting for the DUT.
   stim_step_type    stim_steps[$];
   logic [SYM_W-1:0] symbol_expected[$];
   int unsigned      failures = 0;

   // Handshake flags seen at the last rising edge, read by the driver.
   logic             req_taken = 1'b0;
   logic             csr_taken = 1'b0;
   int unsigned      quiet_cycles = 0;
   int unsigned      idle_left = 0;
   int unsigned      calm_left = 0;

   // The bench's own copy of the node memory, the cursor and the root register.
   logic [IDX_W-1:0] tree_left[NODES];
   logic [IDX_W-1:0] tree_right[NODES];
   logic             tree_leaf[NODES];
   logic [SYM_W-1:0] tree_symbol[NODES];
   logic [IDX_W-1:0] walk_cursor = '0;
   logic [IDX_W-1:0] walk_root   = '0;

   // Which entries the generated stimulus has written so far. Every child of
   // every written non-leaf node is itself written, and the root always is, so
   // no decode can ever read an entry that was never loaded.
   logic [NODES-1:0] gen_written = '0;
   int unsigned      gen_written_list[$];
   int unsigned      request_count = 0;

   always #5 clock = ~clock;

   huffman_tree_walk_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_node_index  (req_node_index),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .req_leaf        (req_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_code_bit    (req_code_bit),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_root_index  (csr_root_index)
   );

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   function automatic stim_step_type node_write_step(input logic [IDX_W-1:0] node,
                                                     input logic [IDX_W-1:0] left,
                                                     input logic [IDX_W-1:0] right,
                                                     input logic             leaf,
                                                     input logic [SYM_W-1:0] symbol);
      stim_step_type s;
      s          = '0;
      s.op       = STEP_REQUEST;
      s.kind     = htwd_pkg::KIND_WRITE;
      s.node     = node;
      s.left     = left;
      s.right    = right;
      s.leaf     = leaf;
      s.symbol   = symbol;
      // The code bit is unused by a node write, so it is left to chance.
      s.code_bit = 1'($urandom_range(0, 1));
      return s;
   endfunction

   // A decode request carries junk in every field it does not use.
   function automatic stim_step_type decode_step(input logic code_bit);
      stim_step_type s;
      s          = '0;
      s.op       = STEP_REQUEST;
      s.kind     = htwd_pkg::KIND_DECODE;
      s.node     = IDX_W'($urandom_range(0, NODES - 1));
      s.left     = IDX_W'($urandom_range(0, NODES - 1));
      s.right    = IDX_W'($urandom_range(0, NODES - 1));
      s.leaf     = 1'($urandom_range(0, 1));
      s.symbol   = SYM_W'($urandom_range(0, 255));
      s.code_bit = code_bit;
      return s;
   endfunction

   function automatic stim_step_type control_step(input step_kind_type op,
                                                  input logic [IDX_W-1:0] root);
      stim_step_type s;
      s      = '0;
      s.op   = op;
      s.root = root;
      return s;
   endfunction

   function automatic logic [IDX_W-1:0] pick_written();
      return IDX_W'(gen_written_list[$urandom_range(0, gen_written_list.size() - 1)]);
   endfunction

   task automatic queue_step(input stim_step_type s);
      stim_steps.insert(stim_steps.size(), s);
      if (s.op == STEP_REQUEST) begin
         request_count++;
         if (s.kind == htwd_pkg::KIND_WRITE && !gen_written[s.node]) begin
            gen_written[s.node] = 1'b1;
            gen_written_list.insert(gen_written_list.size(), 32'(s.node));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Prediction of one accepted request
   // ------------------------------------------------------------------------
   task automatic walk_predict();
      logic [IDX_W-1:0] next;
      if (req_kind == htwd_pkg::KIND_WRITE) begin
         tree_left[req_node_index]   = req_left_index;
         tree_right[req_node_index]  = req_right_index;
         tree_leaf[req_node_index]   = req_leaf;
         tree_symbol[req_node_index] = req_leaf_symbol;
         walk_cursor                 = walk_root;
      end else if (tree_leaf[walk_cursor]) begin
         // A tree made of one leaf yields its symbol on every bit.
         symbol_expected.insert(symbol_expected.size(), tree_symbol[walk_cursor]);
         walk_cursor = walk_root;
      end else begin
         next = req_code_bit ? tree_right[walk_cursor] : tree_left[walk_cursor];
         if (tree_leaf[next]) begin
            symbol_expected.insert(symbol_expected.size(), tree_symbol[next]);
            walk_cursor = walk_root;
         end else begin
            walk_cursor = next;
         end
      end
   endtask

   // Gap before the next request: mostly drawn over the whole range, with
   // occasional calm stretches in which requests follow back to back.
   function automatic int unsigned next_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(10, 40);
      end
      return $urandom_range(0, 14);
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: checks results and updates the model at every rising edge.
   // Results are compared before the model moves, so a request accepted in
   // the same cycle as a symbol never disturbs the order of expectations.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [SYM_W-1:0] want;
      if (!reset) begin
         if (rsp_valid) begin
            if (symbol_expected.size() == 0) begin
               failures++;
               if (failures <= SHOWN_LIMIT) begin
                  $display("unexpected symbol %02h at %0t", rsp_symbol, $realtime);
               end
            end else begin
               want = symbol_expected.pop_front();
               if (rsp_symbol !== want) begin
                  failures++;
                  if (failures <= SHOWN_LIMIT) begin
                     $display("symbol mismatch at %0t: expected %02h, got %02h",
                              $realtime, want, rsp_symbol);
                  end
               end
            end
         end
         if (start && !busy) begin
            walk_predict();
         end
         if (csr_valid && csr_ready) begin
            walk_root   = csr_root_index;
            walk_cursor = csr_root_index;
         end
         req_taken <= start && !busy;
         csr_taken <= csr_valid && csr_ready;
         // Counts cycles in which the block has had nothing to do.
         if (symbol_expected.size() == 0 && !busy && !start && !csr_valid) begin
            quiet_cycles <= quiet_cycles + 1;
         end else begin
            quiet_cycles <= 0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: takes entries from the stimulus queue at each falling edge.
   // The next value of start and csr_valid is worked out first and assigned
   // once, so a request that follows straight on keeps start high.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      logic          start_nxt;
      logic          csr_nxt;
      logic          drained;
      stim_step_type s;
      if (!reset) begin
         start_nxt = start;
         csr_nxt   = csr_valid;
         drained   = symbol_expected.size() == 0 && quiet_cycles >= SETTLE_CYCLES;
         if (start && req_taken) begin
            start_nxt = 1'b0;
         end
         if (csr_valid && csr_taken) begin
            csr_nxt = 1'b0;
         end
         if (!start_nxt && !csr_nxt) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (stim_steps.size() > 0) begin
               s = stim_steps[0];
               case (s.op)
                  STEP_REQUEST: begin
                     void'(stim_steps.pop_front());
                     req_kind        <= s.kind;
                     req_node_index  <= s.node;
                     req_left_index  <= s.left;
                     req_right_index <= s.right;
                     req_leaf        <= s.leaf;
                     req_leaf_symbol <= s.symbol;
                     req_code_bit    <= s.code_bit;
                     start_nxt       = 1'b1;
                     idle_left       = next_gap();
                  end
                  // The root register is only written once the block is idle.
                  STEP_ROOT_WRITE: begin
                     if (drained) begin
                        void'(stim_steps.pop_front());
                        csr_root_index <= s.root;
                        csr_nxt        = 1'b1;
                        idle_left      = next_gap();
                     end
                  end
                  // The sender holds back until every symbol owed has come.
                  default: begin
                     if (drained) begin
                        void'(stim_steps.pop_front());
                     end
                  end
               endcase
            end
         end
         start     <= start_nxt;
         csr_valid <= csr_nxt;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus, reset and the end of the run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [NODES-1:0] batch_map;
      int unsigned      ids[$];
      int unsigned      pool[$];
      stim_step_type    batch[$];
      stim_step_type    tmp;
      int unsigned      leaves;
      int unsigned      idx;
      int unsigned      a;
      int unsigned      b;
      int unsigned      pos;
      int unsigned      tree_root;
      int unsigned      run;
      int               settle_at;
      int               i;
      logic             leaf;

      // Directed part. A small tree spanning both index extremes: node 511 is
      // an internal node with a leaf at 0 on its left and internal node 341 on
      // its right; 341 leads to leaf 170 on bit 0 and back to leaf 0 on bit 1.
      queue_step(node_write_step(9'd511, 9'd0, 9'd341, 1'b0, 8'hA5));
      queue_step(node_write_step(9'd0, 9'd511, 9'd511, 1'b1, 8'hFF));
      queue_step(node_write_step(9'd341, 9'd170, 9'd0, 1'b0, 8'h00));
      queue_step(node_write_step(9'd170, 9'd0, 9'd0, 1'b1, 8'h00));
      // The reset root is node 0, a leaf: each bit yields its symbol.
      queue_step(decode_step(1'b1));
      queue_step(decode_step(1'b0));
      queue_step(control_step(STEP_ROOT_WRITE, 9'd511));
      queue_step(decode_step(1'b0));
      queue_step(decode_step(1'b1));
      queue_step(decode_step(1'b0));
      queue_step(decode_step(1'b1));
      queue_step(decode_step(1'b1));
      // A node write in the middle of a code word sends the walk back to the
      // root, so the following 0 decodes as the root's left leaf.
      queue_step(decode_step(1'b1));
      queue_step(node_write_step(9'd341, 9'd170, 9'd0, 1'b0, 8'h00));
      queue_step(decode_step(1'b0));
      // A long pause part way through a code word must not lose the cursor.
      queue_step(decode_step(1'b1));
      queue_step(control_step(STEP_SETTLE, '0));
      queue_step(decode_step(1'b0));
      queue_step(control_step(STEP_ROOT_WRITE, 9'd0));
      queue_step(decode_step(1'b0));
      queue_step(decode_step(1'b1));
      queue_step(control_step(STEP_ROOT_WRITE, 9'd341));
      queue_step(decode_step(1'b1));
      queue_step(decode_step(1'b0));

      // Random part: each phase loads a fresh tree over random indices, points
      // the root at it and walks it with random bits, with a few node writes
      // thrown in that break code words and reshape the table.
      while (request_count < REQUEST_GOAL) begin
         leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                              : $urandom_range(1, 10);
         batch_map = '0;
         ids.delete();
         pool.delete();
         batch.delete();
         for (i = 0; i < 2 * leaves - 1; i++) begin
            idx = $urandom_range(0, NODES - 1);
            while (batch_map[idx]) begin
               idx = $urandom_range(0, NODES - 1);
            end
            batch_map[idx] = 1'b1;
            ids.insert(ids.size(), idx);
         end
         // Leaves first; the children of a leaf are never followed.
         for (i = 0; i < leaves; i++) begin
            batch.insert(batch.size(),
                         node_write_step(IDX_W'(ids[i]),
                                         IDX_W'($urandom_range(0, NODES - 1)),
                                         IDX_W'($urandom_range(0, NODES - 1)), 1'b1,
                                         SYM_W'($urandom_range(0, 255))));
            pool.insert(pool.size(), ids[i]);
         end
         // Then join two random subtrees under a new parent until one is left.
         i = leaves;
         while (pool.size() > 1) begin
            pos = $urandom_range(0, pool.size() - 1);
            a   = pool[pos];
            pool[pos] = pool[pool.size() - 1];
            void'(pool.pop_back());
            pos = $urandom_range(0, pool.size() - 1);
            b   = pool[pos];
            pool[pos] = pool[pool.size() - 1];
            void'(pool.pop_back());
            batch.insert(batch.size(),
                         node_write_step(IDX_W'(ids[i]), IDX_W'(a), IDX_W'(b), 1'b0,
                                         SYM_W'($urandom_range(0, 255))));
            pool.insert(pool.size(), ids[i]);
            i++;
         end
         tree_root = pool[0];
         // The nodes of one tree are loaded in random order.
         for (i = batch.size() - 1; i > 0; i--) begin
            pos        = $urandom_range(0, i);
            tmp        = batch[i];
            batch[i]   = batch[pos];
            batch[pos] = tmp;
         end
         foreach (batch[i]) begin
            queue_step(batch[i]);
         end

         // Usually the root moves to the new tree, sometimes to any loaded
         // node, and now and then it is left where it was.
         case ($urandom_range(0, 9))
            0:       ;
            1, 2:    queue_step(control_step(STEP_ROOT_WRITE, pick_written()));
            default: queue_step(control_step(STEP_ROOT_WRITE, IDX_W'(tree_root)));
         endcase

         run       = $urandom_range(20, 80);
         settle_at = -1;
         if ($urandom_range(0, 3) == 0) begin
            settle_at = int'($urandom_range(0, run - 1));
         end
         for (i = 0; i < run; i++) begin
            if (i == settle_at) begin
               queue_step(control_step(STEP_SETTLE, '0));
            end
            if ($urandom_range(0, 15) == 0) begin
               leaf = 1'($urandom_range(0, 1));
               if (leaf) begin
                  queue_step(node_write_step(IDX_W'($urandom_range(0, NODES - 1)),
                                             IDX_W'($urandom_range(0, NODES - 1)),
                                             IDX_W'($urandom_range(0, NODES - 1)), 1'b1,
                                             SYM_W'($urandom_range(0, 255))));
               end else begin
                  queue_step(node_write_step(IDX_W'($urandom_range(0, NODES - 1)),
                                             pick_written(), pick_written(), 1'b0,
                                             SYM_W'($urandom_range(0, 255))));
               end
            end else begin
               queue_step(decode_step(1'($urandom_range(0, 1))));
            end
         end
      end
      // Leave the root at the top extreme for the tail of the run.
      queue_step(control_step(STEP_ROOT_WRITE, 9'd511));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_steps.size() != 0 || start || csr_valid || symbol_expected.size() != 0) begin
         @(posedge clock);
      end
      // A walk that ends without a leaf may still be running; let it finish
      // so that any stray symbol is caught.
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      if (failures == 0 && symbol_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest correct run.
   initial begin : watchdog
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule
